// ===== rtl/smpu_pkg.sv =====
// ----------------------------------------------------------------------------
// smpu_pkg
// Shared types and constants of the stack machine primitive unit.
// ----------------------------------------------------------------------------
package smpu_pkg;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_UNDER   = 3'd1;
    localparam logic [2:0] ERR_COLLIDE = 3'd2;
    localparam logic [2:0] ERR_DIV0    = 3'd3;
    localparam logic [2:0] ERR_ADDR    = 3'd4;

    localparam logic [4:0] OP_DROP  = 5'd0;
    localparam logic [4:0] OP_DUP   = 5'd1;
    localparam logic [4:0] OP_SWAP  = 5'd2;
    localparam logic [4:0] OP_TOR   = 5'd3;
    localparam logic [4:0] OP_RFROM = 5'd4;
    localparam logic [4:0] OP_ADD   = 5'd5;
    localparam logic [4:0] OP_SUB   = 5'd6;
    localparam logic [4:0] OP_MUL   = 5'd7;
    localparam logic [4:0] OP_DIV   = 5'd8;
    localparam logic [4:0] OP_MOD   = 5'd9;
    localparam logic [4:0] OP_AND   = 5'd10;
    localparam logic [4:0] OP_OR    = 5'd11;
    localparam logic [4:0] OP_XOR   = 5'd12;
    localparam logic [4:0] OP_EQ    = 5'd13;
    localparam logic [4:0] OP_LT    = 5'd14;
    localparam logic [4:0] OP_GT    = 5'd15;
    localparam logic [4:0] OP_LE    = 5'd16;
    localparam logic [4:0] OP_GE    = 5'd17;
    localparam logic [4:0] OP_NE    = 5'd18;
    localparam logic [4:0] OP_NOT   = 5'd19;
    localparam logic [4:0] OP_FETCH = 5'd20;
    localparam logic [4:0] OP_STORE = 5'd21;
    localparam logic [4:0] OP_CFET  = 5'd22;
    localparam logic [4:0] OP_CSTO  = 5'd23;
    localparam logic [4:0] OP_PRINT = 5'd24;
    localparam logic [4:0] OP_LOOP  = 5'd25;
    localparam logic [4:0] OP_RDROP = 5'd26;
    localparam logic [4:0] OP_IDX   = 5'd27;
    localparam logic [4:0] OP_TWOR  = 5'd28;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_EXEC,
        ST_DIV,
        ST_MEM0,
        ST_MEM1,
        ST_WR,
        ST_WR2,
        ST_TOP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [15:0] a;
        logic [15:0] b;
    } t_div_req;

endpackage

// ===== rtl/stack_machine_primitive_unit.sv =====
// ----------------------------------------------------------------------------
// stack_machine_primitive_unit
// Forth-style execution unit with a shared stack memory and byte memory.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one word per step, either a literal push
// or a primitive number. One result word follows each input word on the
// output channel, giving the new top of the data stack, both depths, any
// printed value and an error code. The block works on one word at a time
// and is not ready while a word is in progress or its result is unread.
// The stack memory, with one read and one write port, sets the pace: each
// word is read in RD0 and RD1, checked in EXEC, written back in WR and WR2,
// and its new top is read in TOP before the result is shown in OUT. This is
// the whole path of a word that needs no byte memory access and no division,
// and of every word that ends in an error. Byte memory loads and stores also
// pass through MEM0 and MEM1, and divide and modulo wait in DIV for the
// one-bit-per-cycle divider. After reset the byte memory is swept clear, one
// byte per cycle, before the first word is accepted. A stalled receiver makes
// the block hold the result until it is taken; no words are lost.
// ----------------------------------------------------------------------------
module stack_machine_primitive_unit #(
    parameter int STACK_WORDS = 64,
    parameter int MEM_BYTES   = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic [4:0]            i_op,
    input  logic signed [15:0]    i_literal,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [15:0]    o_top_value,
    output logic [$clog2(STACK_WORDS+1)-1:0] o_data_depth,
    output logic [$clog2(STACK_WORDS+1)-1:0] o_return_depth,
    output logic                  o_print_valid,
    output logic signed [15:0]    o_print_value,
    output logic [2:0]            o_error_code
);
    localparam int PW = $clog2(STACK_WORDS + 1);
    localparam int AW = $clog2(STACK_WORDS);
    localparam int MW = $clog2(MEM_BYTES);

    smpu_pkg::t_state r_state, n_state;

    logic [15:0] r_stk [STACK_WORDS];
    logic [7:0]  r_mem [MEM_BYTES];

    logic [PW-1:0] r_dp, r_rp, n_dp, n_rp;
    logic [PW-1:0] r_dp_next, r_rp_next;
    logic [MW:0]   r_clr;
    logic          r_func;
    logic [4:0]    r_op;
    logic [15:0]   r_lit, r_a, r_b, r_res, r_pval;
    logic [7:0]    r_lo;
    logic [2:0]    r_err, n_err;
    logic          r_pv, n_pv;
    logic [15:0]   r_sdata;
    logic [7:0]    r_mdata;

    logic          w_swe, w_mwe;
    logic [AW-1:0] w_saddr, w_waddr;
    logic [15:0]   w_swdata;
    logic [MW-1:0] w_maddr;
    logic [7:0]    w_mwdata;
    logic [15:0]   w_alu, w_res2, w_wval;
    logic          w_div_done;
    logic [15:0]   w_div_res;
    smpu_pkg::t_div_req w_dreq;
    logic [PW-1:0] w_dd, w_need_d, w_need_r;
    logic          w_grow, w_unused, w_wide, w_mem_op;
    logic [16:0]   w_addr_end;

    always_ff @(posedge i_clk) begin
        if (w_swe) r_stk[w_waddr] <= w_swdata;
        r_sdata <= r_stk[w_saddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_maddr] <= w_mwdata;
        r_mdata <= r_mem[w_maddr];
    end

    smpu_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_div_done),
        .o_result(w_div_res)
    );

    assign w_dd = PW'(STACK_WORDS) - r_dp;

    always_comb begin
        w_need_d = '0;
        w_need_r = '0;
        w_grow   = 1'b0;
        w_unused = 1'b0;
        case (r_op) inside
            smpu_pkg::OP_DROP, smpu_pkg::OP_TOR, smpu_pkg::OP_NOT, smpu_pkg::OP_FETCH,
            smpu_pkg::OP_CFET, smpu_pkg::OP_PRINT: w_need_d = PW'(1);
            smpu_pkg::OP_DUP: begin
                w_need_d = PW'(1);
                w_grow   = 1'b1;
            end
            smpu_pkg::OP_SWAP, [smpu_pkg::OP_ADD:smpu_pkg::OP_NE], smpu_pkg::OP_STORE,
            smpu_pkg::OP_CSTO, smpu_pkg::OP_TWOR: w_need_d = PW'(2);
            smpu_pkg::OP_RFROM: w_need_r = PW'(1);
            smpu_pkg::OP_LOOP, smpu_pkg::OP_IDX: begin
                w_need_r = PW'(2);
                w_grow   = 1'b1;
            end
            smpu_pkg::OP_RDROP: w_need_r = PW'(2);
            default: w_unused = 1'b1;
        endcase
    end

    assign w_wide     = (r_op == smpu_pkg::OP_FETCH) || (r_op == smpu_pkg::OP_STORE);
    assign w_mem_op   = (r_op == smpu_pkg::OP_FETCH) || (r_op == smpu_pkg::OP_STORE)
                     || (r_op == smpu_pkg::OP_CFET) || (r_op == smpu_pkg::OP_CSTO);
    assign w_addr_end = {1'b0, r_b} + (w_wide ? 17'd1 : 17'd0);

    always_comb begin
        case (r_op)
            smpu_pkg::OP_ADD: w_alu = r_a + r_b;
            smpu_pkg::OP_SUB: w_alu = r_a - r_b;
            smpu_pkg::OP_MUL: w_alu = 16'(r_a * r_b);
            smpu_pkg::OP_AND: w_alu = r_a & r_b;
            smpu_pkg::OP_OR:  w_alu = r_a | r_b;
            smpu_pkg::OP_XOR: w_alu = r_a ^ r_b;
            smpu_pkg::OP_EQ:  w_alu = 16'(r_a == r_b);
            smpu_pkg::OP_LT:  w_alu = 16'($signed(r_a) < $signed(r_b));
            smpu_pkg::OP_GT:  w_alu = 16'($signed(r_a) > $signed(r_b));
            smpu_pkg::OP_LE:  w_alu = 16'($signed(r_a) <= $signed(r_b));
            smpu_pkg::OP_GE:  w_alu = 16'($signed(r_a) >= $signed(r_b));
            smpu_pkg::OP_NE:  w_alu = 16'(r_a != r_b);
            smpu_pkg::OP_NOT: w_alu = 16'(r_b == 16'd0);
            smpu_pkg::OP_LOOP: w_alu = r_a + 16'd1;
            default:          w_alu = r_b;
        endcase
    end
    assign w_res2 = 16'(r_res >= r_b);

    always_comb begin
        w_wval = r_res;
        if (!r_func) begin
            case (r_op) inside
                [smpu_pkg::OP_ADD:smpu_pkg::OP_MUL], [smpu_pkg::OP_AND:smpu_pkg::OP_NE],
                smpu_pkg::OP_NOT, smpu_pkg::OP_LOOP: w_wval = w_alu;
                smpu_pkg::OP_FETCH: w_wval = {r_mdata, r_lo};
                default: w_wval = r_res;
            endcase
        end
    end

    // Reads: RD0 fetches b (data top, return top, or second return entry for IDX), RD1 fetches a.
    always_comb begin
        w_saddr = AW'(r_dp);
        if (r_state == smpu_pkg::ST_RD0) begin
            if (r_op == smpu_pkg::OP_RFROM || r_op == smpu_pkg::OP_LOOP)
                w_saddr = AW'(r_rp - PW'(1));
            else if (r_op == smpu_pkg::OP_IDX)
                w_saddr = AW'(r_rp - PW'(2));
        end else if (r_state == smpu_pkg::ST_RD1) begin
            if (r_op == smpu_pkg::OP_LOOP) w_saddr = AW'(r_rp - PW'(2));
            else                           w_saddr = AW'(r_dp + PW'(1));
        end else if (r_state == smpu_pkg::ST_TOP) begin
            w_saddr = AW'(r_dp);
        end
    end

    always_comb begin
        w_dreq.start  = (r_state == smpu_pkg::ST_EXEC) && !r_func
                     && (r_op == smpu_pkg::OP_DIV || r_op == smpu_pkg::OP_MOD)
                     && n_err == smpu_pkg::ERR_OK;
        w_dreq.is_mod = (r_op == smpu_pkg::OP_MOD);
        w_dreq.a      = r_sdata;
        w_dreq.b      = r_b;
    end

    always_comb begin
        w_mwe    = 1'b0;
        w_maddr  = MW'(r_b);
        w_mwdata = r_a[7:0];
        if (r_state == smpu_pkg::ST_CLEAR) begin
            w_mwe    = 1'b1;
            w_maddr  = MW'(r_clr);
            w_mwdata = 8'd0;
        end else if (r_state == smpu_pkg::ST_MEM0) begin
            w_mwe = (r_op == smpu_pkg::OP_STORE) || (r_op == smpu_pkg::OP_CSTO);
        end else if (r_state == smpu_pkg::ST_MEM1) begin
            w_maddr  = MW'(r_b + 16'd1);
            w_mwdata = r_a[15:8];
            w_mwe    = (r_op == smpu_pkg::OP_STORE);
        end
    end

    // Stack writes happen in WR (primary) and WR2 (second entry).
    always_comb begin
        w_swe    = 1'b0;
        w_waddr  = AW'(r_dp);
        w_swdata = w_wval;
        if (r_state == smpu_pkg::ST_WR && r_err == smpu_pkg::ERR_OK) begin
            if (r_func) begin
                w_swe   = 1'b1;
                w_waddr = AW'(r_dp - PW'(1));
            end else begin
                case (r_op) inside
                    smpu_pkg::OP_DUP, smpu_pkg::OP_RFROM, smpu_pkg::OP_IDX: begin
                        w_swe   = 1'b1;
                        w_waddr = AW'(r_dp - PW'(1));
                    end
                    smpu_pkg::OP_SWAP: begin
                        w_swe    = 1'b1;
                        w_swdata = r_a;
                    end
                    smpu_pkg::OP_TOR, smpu_pkg::OP_TWOR: begin
                        w_swe    = 1'b1;
                        w_waddr  = AW'(r_rp);
                        w_swdata = r_b;
                    end
                    [smpu_pkg::OP_ADD:smpu_pkg::OP_NE]: begin
                        w_swe   = 1'b1;
                        w_waddr = AW'(r_dp + PW'(1));
                    end
                    smpu_pkg::OP_NOT, smpu_pkg::OP_FETCH, smpu_pkg::OP_CFET: w_swe = 1'b1;
                    smpu_pkg::OP_LOOP: begin
                        w_swe   = 1'b1;
                        w_waddr = AW'(r_rp - PW'(2));
                    end
                    default: w_swe = 1'b0;
                endcase
            end
        end else if (r_state == smpu_pkg::ST_WR2 && r_err == smpu_pkg::ERR_OK && !r_func) begin
            if (r_op == smpu_pkg::OP_SWAP) begin
                w_swe    = 1'b1;
                w_waddr  = AW'(r_dp + PW'(1));
                w_swdata = r_b;
            end else if (r_op == smpu_pkg::OP_TWOR) begin
                w_swe    = 1'b1;
                w_waddr  = AW'(r_rp + PW'(1));
                w_swdata = r_a;
            end else if (r_op == smpu_pkg::OP_LOOP) begin
                w_swe    = 1'b1;
                w_waddr  = AW'(r_dp - PW'(1));
                w_swdata = w_res2;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            smpu_pkg::ST_CLEAR:
                if (r_clr == (MW+1)'(MEM_BYTES - 1)) n_state = smpu_pkg::ST_IDLE;
            smpu_pkg::ST_IDLE:
                if (i_valid) n_state = smpu_pkg::ST_RD0;
            smpu_pkg::ST_RD0:  n_state = smpu_pkg::ST_RD1;
            smpu_pkg::ST_RD1:  n_state = smpu_pkg::ST_EXEC;
            smpu_pkg::ST_EXEC: begin
                if (n_err != smpu_pkg::ERR_OK || r_func) n_state = smpu_pkg::ST_WR;
                else if (w_dreq.start)                 n_state = smpu_pkg::ST_DIV;
                else if (w_mem_op)                     n_state = smpu_pkg::ST_MEM0;
                else                                   n_state = smpu_pkg::ST_WR;
            end
            smpu_pkg::ST_DIV:
                if (w_div_done) n_state = smpu_pkg::ST_WR;
            smpu_pkg::ST_MEM0: n_state = smpu_pkg::ST_MEM1;
            smpu_pkg::ST_MEM1: n_state = smpu_pkg::ST_WR;
            smpu_pkg::ST_WR:   n_state = smpu_pkg::ST_WR2;
            smpu_pkg::ST_WR2:  n_state = smpu_pkg::ST_TOP;
            smpu_pkg::ST_TOP:  n_state = smpu_pkg::ST_OUT;
            smpu_pkg::ST_OUT:
                if (i_ready) n_state = smpu_pkg::ST_IDLE;
            default: n_state = smpu_pkg::ST_IDLE;
        endcase
    end

    // Error checks and pointer updates, evaluated in EXEC.
    always_comb begin
        n_err = smpu_pkg::ERR_OK;
        n_pv  = 1'b0;
        n_dp  = r_dp;
        n_rp  = r_rp;
        if (r_func) begin
            if (r_dp == r_rp) n_err = smpu_pkg::ERR_COLLIDE;
            else              n_dp  = r_dp - PW'(1);
        end else if (!w_unused) begin
            if (w_dd < w_need_d || r_rp < w_need_r) begin
                n_err = smpu_pkg::ERR_UNDER;
            end else if (w_grow && r_dp == r_rp) begin
                n_err = smpu_pkg::ERR_COLLIDE;
            end else if ((r_op == smpu_pkg::OP_DIV || r_op == smpu_pkg::OP_MOD)
                         && r_b == 16'd0) begin
                n_err = smpu_pkg::ERR_DIV0;
            end else if (w_mem_op && w_addr_end >= 17'(MEM_BYTES)) begin
                n_err = smpu_pkg::ERR_ADDR;
            end else begin
                case (r_op) inside
                    smpu_pkg::OP_DROP: n_dp = r_dp + PW'(1);
                    smpu_pkg::OP_PRINT: begin
                        n_dp = r_dp + PW'(1);
                        n_pv = 1'b1;
                    end
                    smpu_pkg::OP_DUP, smpu_pkg::OP_LOOP, smpu_pkg::OP_IDX:
                        n_dp = r_dp - PW'(1);
                    smpu_pkg::OP_TOR: begin
                        n_dp = r_dp + PW'(1);
                        n_rp = r_rp + PW'(1);
                    end
                    smpu_pkg::OP_RFROM: begin
                        n_dp = r_dp - PW'(1);
                        n_rp = r_rp - PW'(1);
                    end
                    [smpu_pkg::OP_ADD:smpu_pkg::OP_NE]: n_dp = r_dp + PW'(1);
                    smpu_pkg::OP_STORE, smpu_pkg::OP_CSTO: n_dp = r_dp + PW'(2);
                    smpu_pkg::OP_RDROP: n_rp = r_rp - PW'(2);
                    smpu_pkg::OP_TWOR: begin
                        n_dp = r_dp + PW'(2);
                        n_rp = r_rp + PW'(2);
                    end
                    default: n_dp = r_dp;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smpu_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_dp    <= PW'(STACK_WORDS);
            r_rp    <= '0;
            r_err   <= smpu_pkg::ERR_OK;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == smpu_pkg::ST_CLEAR) r_clr <= r_clr + (MW+1)'(1);
            if (r_state == smpu_pkg::ST_EXEC) begin
                r_err <= n_err;
                r_pv  <= n_pv;
            end
            // Pointers move after the writes that use the old values.
            if (r_state == smpu_pkg::ST_WR2 && r_err == smpu_pkg::ERR_OK) begin
                r_dp <= r_dp_next;
                r_rp <= r_rp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == smpu_pkg::ST_IDLE && i_valid) begin
            r_func <= i_func;
            r_op   <= i_op;
            r_lit  <= i_literal;
        end
        if (r_state == smpu_pkg::ST_RD1) r_b <= r_sdata;
        if (r_state == smpu_pkg::ST_EXEC) begin
            r_a       <= r_sdata;
            r_dp_next <= n_dp;
            r_rp_next <= n_rp;
            r_pval    <= n_pv ? r_b : 16'd0;
            r_res     <= r_func ? r_lit : r_b;
        end
        if (r_state == smpu_pkg::ST_MEM0 && r_err == smpu_pkg::ERR_OK) begin
            r_res <= 16'(w_alu);
        end
        if (r_state == smpu_pkg::ST_MEM1) begin
            r_lo <= r_mdata;
            if (r_op == smpu_pkg::OP_CFET) r_res <= {8'd0, r_mdata};
        end
        if (r_state == smpu_pkg::ST_DIV && w_div_done) r_res <= w_div_res;
        if (r_state == smpu_pkg::ST_WR) r_res <= w_wval;
    end

    assign o_ready        = (r_state == smpu_pkg::ST_IDLE);
    assign o_valid        = (r_state == smpu_pkg::ST_OUT);
    assign o_top_value    = (r_dp == PW'(STACK_WORDS)) ? 16'sd0 : $signed(r_sdata);
    assign o_data_depth   = w_dd;
    assign o_return_depth = r_rp;
    assign o_print_valid  = r_pv;
    assign o_print_value  = $signed(r_pval);
    assign o_error_code   = r_err;

    property p_ready_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && !o_ready;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("result dropped");

    property p_not_both;
        @(posedge i_clk) disable iff (!i_rst_n) !(o_ready && o_valid);
    endproperty
    a_not_both: assert property (p_not_both) else $error("ready during result");

    property p_no_cross;
        @(posedge i_clk) disable iff (!i_rst_n) r_rp <= r_dp;
    endproperty
    a_no_cross: assert property (p_no_cross) else $error("stacks crossed");

    property p_print_err;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_print_valid |-> o_error_code == smpu_pkg::ERR_OK;
    endproperty
    a_print_err: assert property (p_print_err) else $error("print with error");
endmodule

// ===== rtl/smpu_divider.sv =====
// ----------------------------------------------------------------------------
// smpu_divider
// Signed 16-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smpu_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smpu_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [15:0]       o_result
);
    logic [15:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done, r_qneg, r_rneg, r_mod;
    logic [16:0] w_trial;
    logic [15:0] w_abs_a, w_abs_b;

    assign w_abs_a = i_req.a[15] ? 16'(-i_req.a) : i_req.a;
    assign w_abs_b = i_req.b[15] ? 16'(-i_req.b) : i_req.b;
    assign w_trial = {r_rem[15:0], r_quo[15]} - {1'b0, r_div};

    always_comb begin
        n_rem = {r_rem[15:0], r_quo[15]};
        n_quo = {r_quo[14:0], 1'b0};
        if (!w_trial[16]) begin
            n_rem    = w_trial;
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= w_abs_a;
            r_rem  <= '0;
            r_div  <= w_abs_b;
            r_qneg <= i_req.a[15] ^ i_req.b[15];
            r_rneg <= i_req.a[15];
            r_mod  <= i_req.is_mod;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_mod ? (r_rneg ? 16'(-r_rem[15:0]) : r_rem[15:0])
                            : (r_qneg ? 16'(-r_quo) : r_quo);
endmodule
